[hdl/i2cbw_pkg.sv]
// Shared types and constants for the I2C master byte writer.
// No dependencies; every other file of the block but i2cbw_check uses this package.
package i2cbw_pkg;

   localparam int unsigned HALF_W    = 8;
   localparam int unsigned STRETCH_W = 14;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned BITCNT_W  = 4;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 14;

   localparam logic [HALF_W-1:0]    HALF_PHASE_RESET = 8'd5;
   localparam logic [STRETCH_W-1:0] STRETCH_RESET    = 14'd10000;
   localparam logic [BITCNT_W-1:0]  DATA_BITS        = 4'd8;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PHASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRETCH    = 2'd1;

   // Command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SEND = 1'b1;

   // Bus sequencer phases, one-hot
   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_LOW     = 5'b00010,
      PH_DATA    = 5'b00100,
      PH_STRETCH = 5'b01000,
      PH_HIGH    = 5'b10000
   } phase_type;

   typedef struct packed {
      logic              cmd;
      logic [BYTE_W-1:0] byte_in;
      logic              scl_level;
      logic              sda_level;
   } req_type;

   typedef struct packed {
      logic scl_drive_low;
      logic sda_drive_low;
      logic busy_res;
      logic done_res;
      logic acked;
      logic stretch_expired;
   } rsp_type;

endpackage

[hdl/i2cbw_if.sv]
// Valid/ready channel interfaces: tick/command input, result output, register writes.
// Depends on i2cbw_pkg for field widths.
interface i2cbw_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [i2cbw_pkg::BYTE_W-1:0]  byte_in;
   logic                          scl_level;
   logic                          sda_level;

   modport source (output valid, cmd, byte_in, scl_level, sda_level, input ready);
   modport sink   (input valid, cmd, byte_in, scl_level, sda_level, output ready);
endinterface

interface i2cbw_rsp_if;
   logic valid;
   logic ready;
   logic scl_drive_low;
   logic sda_drive_low;
   logic busy_res;
   logic done_res;
   logic acked;
   logic stretch_expired;

   modport source (output valid, scl_drive_low, sda_drive_low, busy_res, done_res, acked,
                   stretch_expired, input ready);
   modport sink   (input valid, scl_drive_low, sda_drive_low, busy_res, done_res, acked,
                   stretch_expired, output ready);
endinterface

interface i2cbw_csr_if;
   logic                            valid;
   logic                            ready;
   logic [i2cbw_pkg::CSR_IDX_W-1:0] index;
   logic [i2cbw_pkg::CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hdl/i2cbw_seq.sv]
// Bit sequencer: phase register, shift register, delay and stretch counters.
// Depends on i2cbw_pkg; steps once per accepted word and reports the updated drives.
module i2cbw_seq (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  i2cbw_pkg::req_type                   req,
   input  logic [i2cbw_pkg::HALF_W-1:0]         half_phase_ticks,
   input  logic [i2cbw_pkg::STRETCH_W-1:0]      stretch_limit,
   output i2cbw_pkg::rsp_type                   rsp_next
);
   import i2cbw_pkg::*;

   phase_type             phase_ff,         phase_in;
   logic [BYTE_W-1:0]     shift_ff,         shift_in;
   logic [BITCNT_W-1:0]   bit_count_ff,     bit_count_in;
   logic [HALF_W-1:0]     wait_count_ff,    wait_count_in;
   logic [STRETCH_W-1:0]  stretch_count_ff, stretch_count_in;
   logic                  ack_ff,           ack_in;
   logic                  expired_ff,       expired_in;
   logic                  scl_hold_ff,      scl_hold_in;
   logic                  sda_hold_ff,      sda_hold_in;
   logic                  done;

   logic [HALF_W-1:0]     half_lim;
   logic [STRETCH_W-1:0]  stretch_lim;
   logic [HALF_W-1:0]     wait_inc;
   logic [STRETCH_W-1:0]  stretch_inc;
   logic                  delay_hit;
   logic                  stretch_hit;
   logic                  data_left;

   // Zero limits act as one
   assign half_lim    = (half_phase_ticks == '0) ? HALF_W'(1) : half_phase_ticks;
   assign stretch_lim = (stretch_limit == '0) ? STRETCH_W'(1) : stretch_limit;
   assign wait_inc    = wait_count_ff + HALF_W'(1);
   assign stretch_inc = stretch_count_ff + STRETCH_W'(1);
   assign delay_hit   = (wait_inc >= half_lim);
   assign stretch_hit = (stretch_inc >= stretch_lim);
   assign data_left   = (bit_count_ff < DATA_BITS);

   // Next state for one word
   always_comb begin
      phase_in         = phase_ff;
      shift_in         = shift_ff;
      bit_count_in     = bit_count_ff;
      wait_count_in    = wait_count_ff;
      stretch_count_in = stretch_count_ff;
      ack_in           = ack_ff;
      expired_in       = expired_ff;
      scl_hold_in      = scl_hold_ff;
      sda_hold_in      = sda_hold_ff;
      done             = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (req.cmd == CMD_SEND) begin
               shift_in         = req.byte_in;
               bit_count_in     = '0;
               wait_count_in    = '0;
               stretch_count_in = '0;
               ack_in           = 1'b0;
               expired_in       = 1'b0;
               scl_hold_in      = 1'b1;
               phase_in         = PH_LOW;
            end
         end
         PH_LOW: begin
            wait_count_in = delay_hit ? '0 : wait_inc;
            if (delay_hit) begin
               if (data_left) begin
                  sda_hold_in = ~shift_ff[BYTE_W-1];
                  phase_in    = PH_DATA;
               end else begin
                  // acknowledge clock skips the data setup
                  scl_hold_in      = 1'b0;
                  stretch_count_in = '0;
                  phase_in         = PH_STRETCH;
               end
            end
         end
         PH_DATA: begin
            wait_count_in = delay_hit ? '0 : wait_inc;
            if (delay_hit) begin
               scl_hold_in      = 1'b0;
               stretch_count_in = '0;
               phase_in         = PH_STRETCH;
            end
         end
         PH_STRETCH: begin
            if (req.scl_level) begin
               wait_count_in = '0;
               phase_in      = PH_HIGH;
            end else begin
               stretch_count_in = stretch_inc;
               if (stretch_hit) begin
                  // give up on the stretch and carry on
                  expired_in    = 1'b1;
                  wait_count_in = '0;
                  phase_in      = PH_HIGH;
               end
            end
         end
         PH_HIGH: begin
            wait_count_in = delay_hit ? '0 : wait_inc;
            if (delay_hit) begin
               scl_hold_in = 1'b1;
               if (data_left) begin
                  shift_in     = {shift_ff[BYTE_W-2:0], 1'b0};
                  bit_count_in = bit_count_ff + BITCNT_W'(1);
                  if (bit_count_in == DATA_BITS) begin
                     sda_hold_in = 1'b0;
                  end
                  phase_in = PH_LOW;
               end else begin
                  ack_in   = ~req.sda_level;
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Advance on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         shift_ff         <= '0;
         bit_count_ff     <= '0;
         wait_count_ff    <= '0;
         stretch_count_ff <= '0;
         ack_ff           <= 1'b0;
         expired_ff       <= 1'b0;
         scl_hold_ff      <= 1'b0;
         sda_hold_ff      <= 1'b0;
      end else if (step) begin
         phase_ff         <= phase_in;
         shift_ff         <= shift_in;
         bit_count_ff     <= bit_count_in;
         wait_count_ff    <= wait_count_in;
         stretch_count_ff <= stretch_count_in;
         ack_ff           <= ack_in;
         expired_ff       <= expired_in;
         scl_hold_ff      <= scl_hold_in;
         sda_hold_ff      <= sda_hold_in;
      end
   end

   // Result word reflects the updated state
   always_comb begin
      rsp_next.scl_drive_low   = scl_hold_in;
      rsp_next.sda_drive_low   = sda_hold_in;
      rsp_next.busy_res        = (phase_in != PH_IDLE);
      rsp_next.done_res        = done;
      rsp_next.acked           = ack_in;
      rsp_next.stretch_expired = expired_in;
   end

endmodule

[hdl/i2c_master_byte_writer.sv]
// Top level of the I2C master byte writer: channels, configuration registers, result register.
// Depends on i2cbw_pkg, the channel interfaces and i2cbw_seq.
//
//   channel   dir  word                                        accepted when
//   req_bus   in   cmd, byte_in, scl_level, sda_level          valid && ready
//   rsp_bus   out  scl/sda drives, busy, done, acked, expired  valid && ready
//   csr_bus   in   index, data (register writes)               valid && ready
//
// The sequencer updates on the accepting edge and the result lands in the output
// register on that same edge; one word per cycle while rsp_bus is not stalled.
// A stalled result holds in the output register; req_bus.ready follows
// rsp_bus.ready while a result waits. csr_bus is always ready.
// Reset (synchronous) idles the sequencer, empties the output register and
// reloads delay 5 and stretch limit 10000.
module i2c_master_byte_writer (
   input logic          clock,
   input logic          reset,
   i2cbw_req_if.sink    req_bus,
   i2cbw_rsp_if.source  rsp_bus,
   i2cbw_csr_if.sink    csr_bus
);
   import i2cbw_pkg::*;

   logic [HALF_W-1:0]    half_ff;
   logic [STRETCH_W-1:0] stretch_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff;
   rsp_type              rsp_next;
   req_type              req_word;
   logic                 req_take;

   // Take a new word when the output register is free or being emptied
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign req_word.cmd       = req_bus.cmd;
   assign req_word.byte_in   = req_bus.byte_in;
   assign req_word.scl_level = req_bus.scl_level;
   assign req_word.sda_level = req_bus.sda_level;

   i2cbw_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .step             (req_take),
      .req              (req_word),
      .half_phase_ticks (half_ff),
      .stretch_limit    (stretch_ff),
      .rsp_next         (rsp_next)
   );

   // Configuration registers; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff    <= HALF_PHASE_RESET;
         stretch_ff <= STRETCH_RESET;
      end else if (csr_bus.valid) begin
         if (csr_bus.index == CSR_HALF_PHASE) begin
            half_ff <= csr_bus.data[HALF_W-1:0];
         end
         if (csr_bus.index == CSR_STRETCH) begin
            stretch_ff <= csr_bus.data[STRETCH_W-1:0];
         end
      end
   end

   // Output register
   assign rsp_valid_in = req_take || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.scl_drive_low   = rsp_ff.scl_drive_low;
   assign rsp_bus.sda_drive_low   = rsp_ff.sda_drive_low;
   assign rsp_bus.busy_res        = rsp_ff.busy_res;
   assign rsp_bus.done_res        = rsp_ff.done_res;
   assign rsp_bus.acked           = rsp_ff.acked;
   assign rsp_bus.stretch_expired = rsp_ff.stretch_expired;

endmodule

[hdl/i2cbw_check.sv]
// Port-level checks for i2c_master_byte_writer, attached by the bind below.
// Depends only on the top level's channel signals.
module i2cbw_check (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic scl_drive_low,
   input logic sda_drive_low,
   input logic busy_res,
   input logic done_res,
   input logic acked,
   input logic stretch_expired
);

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({scl_drive_low, sda_drive_low, busy_res, done_res, acked,
                     stretch_expired}))
      else $error("result word changed while stalled");

   // The finishing word shows the block idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> !busy_res)
      else $error("done with busy still set");

   // The last clock is pulled low when the byte finishes
   a_done_scl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> scl_drive_low)
      else $error("SCL released at end of byte");

   // Leaving reset: output empty, input open
   a_reset_exit: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid && req_ready)
      else $error("channels not cleared by reset");

endmodule

bind i2c_master_byte_writer i2cbw_check u_check (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .scl_drive_low   (rsp_bus.scl_drive_low),
   .sda_drive_low   (rsp_bus.sda_drive_low),
   .busy_res        (rsp_bus.busy_res),
   .done_res        (rsp_bus.done_res),
   .acked           (rsp_bus.acked),
   .stretch_expired (rsp_bus.stretch_expired)
);

[verif/i2c_master_byte_writer_tb.sv]
// Self-checking testbench for i2c_master_byte_writer: directed table, then random phases.
// Depends on i2cbw_pkg, the channel interfaces in hdl/ and the top level of the block.
module i2c_master_byte_writer_tb;
   import i2cbw_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned PHASE_COUNT  = 10;
   localparam int unsigned PHASE_WORDS  = 150;
   localparam int unsigned HOLD_AT      = 300;
   localparam int unsigned HOLD_CYCLES  = 250;
   localparam int unsigned CALM_FROM    = 900;
   localparam int unsigned CALM_TO      = 1150;

   // Register indexes that decode to nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   // Fields: scl_drive_low, sda_drive_low, busy_res, done_res, acked, stretch_expired
   localparam rsp_type RSP_QUIET   = 6'b00_0000;
   localparam rsp_type RSP_STARTED = 6'b10_1000;

   typedef struct {
      bit                   is_write;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [CSR_DAT_W-1:0] reg_data;
      req_type              word;
      bit                   typed;
      rsp_type              want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   i2cbw_req_if req_bus ();
   i2cbw_rsp_if rsp_bus ();
   i2cbw_csr_if csr_bus ();

   i2c_master_byte_writer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Bus sequencer model state and its configuration copy
   logic [BYTE_W-1:0]    sh_byte;
   logic [BITCNT_W-1:0]  bits_sent;
   phase_type            seq_phase;
   logic [HALF_W-1:0]    tick_count;
   logic [STRETCH_W-1:0] stretch_ticks;
   logic                 ack_q;
   logic                 expired_q;
   logic                 scl_q;
   logic                 sda_q;
   logic [HALF_W-1:0]    half_ticks;
   logic [STRETCH_W-1:0] stretch_max;

   rsp_type      bus_result_q [$];
   plan_row_type plan [$];

   bit      typed_on;
   rsp_type typed_val;
   int      mismatches;
   int      cycle_no;
   int      rand_items;
   int      words_in;
   int      words_out;
   int      bytes_done;
   int      bytes_acked;
   int      bytes_expired;
   int      reg_writes;
   int      hold_left;
   bit      held;
   logic    calm;

   assign calm = (rand_items >= CALM_FROM) && (rand_items < CALM_TO);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Count one delay tick; true when the delay phase has run out
   function automatic bit delay_elapsed();
      logic [HALF_W-1:0] lim;
      lim = (half_ticks == '0) ? 8'd1 : half_ticks;
      tick_count = tick_count + 8'd1;
      if (tick_count >= lim) begin
         tick_count = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advance the sequencer model by one word and form the pins it shows
   task automatic advance_sequencer(input req_type w, output rsp_type r);
      logic [STRETCH_W-1:0] slim;
      bit                   fin;
      fin = 1'b0;
      case (seq_phase)
         PH_IDLE: begin
            if (w.cmd == CMD_SEND) begin
               sh_byte       = w.byte_in;
               bits_sent     = '0;
               tick_count    = '0;
               stretch_ticks = '0;
               ack_q         = 1'b0;
               expired_q     = 1'b0;
               scl_q         = 1'b1;
               seq_phase     = PH_LOW;
            end
         end
         PH_LOW: begin
            if (delay_elapsed()) begin
               if (bits_sent < DATA_BITS) begin
                  sda_q     = ~sh_byte[BYTE_W-1];
                  seq_phase = PH_DATA;
               end else begin
                  // acknowledge clock: no SDA setup
                  scl_q         = 1'b0;
                  stretch_ticks = '0;
                  seq_phase     = PH_STRETCH;
               end
            end
         end
         PH_DATA: begin
            if (delay_elapsed()) begin
               scl_q         = 1'b0;
               stretch_ticks = '0;
               seq_phase     = PH_STRETCH;
            end
         end
         PH_STRETCH: begin
            if (w.scl_level) begin
               tick_count = '0;
               seq_phase  = PH_HIGH;
            end else begin
               slim          = (stretch_max == '0) ? 14'd1 : stretch_max;
               stretch_ticks = stretch_ticks + 14'd1;
               if (stretch_ticks >= slim) begin
                  // give up waiting and carry on as if SCL rose
                  expired_q  = 1'b1;
                  tick_count = '0;
                  seq_phase  = PH_HIGH;
               end
            end
         end
         PH_HIGH: begin
            if (delay_elapsed()) begin
               scl_q = 1'b1;
               if (bits_sent < DATA_BITS) begin
                  sh_byte   = {sh_byte[BYTE_W-2:0], 1'b0};
                  bits_sent = bits_sent + 4'd1;
                  if (bits_sent == DATA_BITS)
                     sda_q = 1'b0;
                  seq_phase = PH_LOW;
               end else begin
                  ack_q     = ~w.sda_level;
                  seq_phase = PH_IDLE;
                  fin       = 1'b1;
               end
            end
         end
         default: seq_phase = PH_IDLE;
      endcase
      r.scl_drive_low   = scl_q;
      r.sda_drive_low   = sda_q;
      r.busy_res        = (seq_phase != PH_IDLE);
      r.done_res        = fin;
      r.acked           = ack_q;
      r.stretch_expired = expired_q;
   endtask

   task automatic report(input string field, input logic want, input logic got);
      $display("[%0d] mismatch on %s: expected %0b, got %0b (word %0d)",
               cycle_no, field, want, got, words_out);
      mismatches++;
   endtask

   // Track accepted words, predict and compare at each rising edge
   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.scl_drive_low   = rsp_bus.scl_drive_low;
            got.sda_drive_low   = rsp_bus.sda_drive_low;
            got.busy_res        = rsp_bus.busy_res;
            got.done_res        = rsp_bus.done_res;
            got.acked           = rsp_bus.acked;
            got.stretch_expired = rsp_bus.stretch_expired;
            words_out++;
            if (bus_result_q.size() == 0) begin
               $display("[%0d] result word with nothing pending", cycle_no);
               mismatches++;
            end else begin
               want = bus_result_q.pop_front();
               if (got.scl_drive_low !== want.scl_drive_low)
                  report("scl_drive_low", want.scl_drive_low, got.scl_drive_low);
               if (got.sda_drive_low !== want.sda_drive_low)
                  report("sda_drive_low", want.sda_drive_low, got.sda_drive_low);
               if (got.busy_res !== want.busy_res)
                  report("busy_res", want.busy_res, got.busy_res);
               if (got.done_res !== want.done_res)
                  report("done_res", want.done_res, got.done_res);
               if (got.acked !== want.acked)
                  report("acked", want.acked, got.acked);
               if (got.stretch_expired !== want.stretch_expired)
                  report("stretch_expired", want.stretch_expired, got.stretch_expired);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            advance_sequencer('{cmd: req_bus.cmd, byte_in: req_bus.byte_in,
                                scl_level: req_bus.scl_level,
                                sda_level: req_bus.sda_level}, want);
            words_in++;
            if (want.done_res) begin
               bytes_done++;
               if (want.acked) bytes_acked++;
               if (want.stretch_expired) bytes_expired++;
            end
            bus_result_q.push_back(typed_on ? typed_val : want);
         end
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.index == CSR_HALF_PHASE)
               half_ticks = csr_bus.data[HALF_W-1:0];
            else if (csr_bus.index == CSR_STRETCH)
               stretch_max = csr_bus.data;
            reg_writes++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_no++;
      if (cycle_no >= CYCLE_LIMIT) begin
         $display("[%0d] run did not finish in time", cycle_no);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result receiver: random stalls, one long hold-off, a calm window
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && rand_items >= HOLD_AT) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else if (calm) begin
            rsp_bus.ready = 1'b1;
         end else begin
            rsp_bus.ready = ($urandom_range(0, 99) >= 20);
         end
      end
   end

   // Move to the next falling edge, sometimes idling the sender first
   task automatic pause_sender();
      @(negedge clock);
      if (!calm && $urandom_range(0, 99) < 20) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   endtask

   // Present one word and hold it until the block takes it
   task automatic offer_word(input req_type w);
      req_bus.valid     = 1'b1;
      req_bus.cmd       = w.cmd;
      req_bus.byte_in   = w.byte_in;
      req_bus.scl_level = w.scl_level;
      req_bus.sda_level = w.sda_level;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Idle the sender, drain the results, then write one register (call at a falling edge)
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] val);
      req_bus.valid = 1'b0;
      while (bus_result_q.size() != 0) @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = val;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Finish any byte in flight at the shortest delay, then write one register
   task automatic program_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DAT_W-1:0] val);
      req_type w;
      @(negedge clock);
      if (seq_phase != PH_IDLE) begin
         write_reg(CSR_HALF_PHASE, CSR_DAT_W'(1));
         forever begin
            pause_sender();
            if (seq_phase == PH_IDLE) break;
            typed_on    = 1'b0;
            w.cmd       = CMD_TICK;
            w.byte_in   = BYTE_W'($urandom_range(0, 255));
            w.scl_level = 1'b1;
            w.sda_level = 1'($urandom_range(0, 1));
            offer_word(w);
         end
      end
      write_reg(idx, val);
   endtask

   task automatic add_word(input logic c, input logic [BYTE_W-1:0] b, input logic scl,
                           input logic sda, input bit typed, input rsp_type want);
      plan_row_type row;
      row.is_write = 1'b0;
      row.reg_idx  = '0;
      row.reg_data = '0;
      row.word     = '{cmd: c, byte_in: b, scl_level: scl, sda_level: sda};
      row.typed    = typed;
      row.want     = want;
      plan.push_back(row);
   endtask

   task automatic add_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      plan_row_type row;
      row.is_write = 1'b1;
      row.reg_idx  = idx;
      row.reg_data = val;
      row.word     = '0;
      row.typed    = 1'b0;
      row.want     = RSP_QUIET;
      plan.push_back(row);
   endtask

   initial begin : stimulus
      req_type              w;
      logic [HALF_W-1:0]    half;
      logic [STRETCH_W-1:0] slim;
      logic [5:0]           junk;
      int                   p_scl;

      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_TICK;
      req_bus.byte_in   = '0;
      req_bus.scl_level = 1'b0;
      req_bus.sda_level = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_HALF_PHASE;
      csr_bus.data      = '0;
      typed_on          = 1'b0;
      typed_val         = RSP_QUIET;

      // reset values of the model
      sh_byte       = '0;
      bits_sent     = '0;
      seq_phase     = PH_IDLE;
      tick_count    = '0;
      stretch_ticks = '0;
      ack_q         = 1'b0;
      expired_q     = 1'b0;
      scl_q         = 1'b0;
      sda_q         = 1'b0;
      half_ticks    = HALF_PHASE_RESET;
      stretch_max   = STRETCH_RESET;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: idle ticks, send at reset setting, send while busy
      add_word(CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b1, RSP_QUIET);
      add_word(CMD_TICK, 8'hFF, 1'b1, 1'b1, 1'b1, RSP_QUIET);
      add_word(CMD_SEND, 8'hFF, 1'b1, 1'b1, 1'b1, RSP_STARTED);
      add_word(CMD_SEND, 8'h00, 1'b1, 1'b0, 1'b0, RSP_QUIET);
      add_word(CMD_TICK, 8'h55, 1'b0, 1'b1, 1'b0, RSP_QUIET);
      add_word(CMD_TICK, 8'hAA, 1'b1, 1'b0, 1'b0, RSP_QUIET);
      // zero delay and zero stretch limit (junk above the delay byte), spare indexes
      add_write(CSR_HALF_PHASE, 14'h3F00);
      add_write(CSR_STRETCH, 14'h0000);
      add_write(CSR_SPARE_A, 14'h3FFF);
      add_write(CSR_SPARE_B, 14'h0000);
      add_word(CMD_SEND, 8'h00, 1'b0, 1'b0, 1'b1, RSP_STARTED);
      // hold SCL low so every stretch wait times out
      repeat (6) add_word(CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0, RSP_QUIET);
      add_word(CMD_SEND, 8'hFF, 1'b0, 1'b0, 1'b0, RSP_QUIET);
      add_word(CMD_TICK, 8'hFF, 1'b1, 1'b1, 1'b0, RSP_QUIET);
      // top of both ranges
      add_write(CSR_HALF_PHASE, 14'h00FF);
      add_write(CSR_STRETCH, 14'h3FFF);
      add_word(CMD_SEND, 8'hA5, 1'b1, 1'b1, 1'b1, RSP_STARTED);
      add_word(CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0, RSP_QUIET);
      add_word(CMD_TICK, 8'h00, 1'b1, 1'b1, 1'b0, RSP_QUIET);
      // run one full delay phase at the longest setting
      repeat (256) add_word(CMD_TICK, 8'h00, 1'b1, 1'b1, 1'b0, RSP_QUIET);
      // bottom of both ranges
      add_write(CSR_HALF_PHASE, 14'h0001);
      add_write(CSR_STRETCH, 14'h0001);
      add_word(CMD_SEND, 8'h5A, 1'b1, 1'b0, 1'b1, RSP_STARTED);
      add_word(CMD_TICK, 8'h5A, 1'b1, 1'b0, 1'b0, RSP_QUIET);
      add_word(CMD_TICK, 8'h5A, 1'b1, 1'b1, 1'b0, RSP_QUIET);
      add_word(CMD_TICK, 8'h5A, 1'b0, 1'b0, 1'b0, RSP_QUIET);
      add_word(CMD_TICK, 8'h5A, 1'b1, 1'b1, 1'b0, RSP_QUIET);
      add_word(CMD_TICK, 8'h5A, 1'b0, 1'b1, 1'b0, RSP_QUIET);

      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            program_reg(plan[i].reg_idx, plan[i].reg_data);
         end else begin
            pause_sender();
            typed_on  = plan[i].typed;
            typed_val = plan[i].want;
            offer_word(plan[i].word);
         end
      end

      // Random phases, each with its own delay, stretch limit and SCL behavior
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: begin
               half  = HALF_PHASE_RESET;
               slim  = STRETCH_RESET;
               p_scl = 90;
            end
            1: begin
               half  = 8'd1;
               slim  = 14'd1;
               p_scl = 50;
            end
            2: begin
               half  = 8'd255;
               slim  = 14'h3FFF;
               p_scl = 90;
            end
            3: begin
               half  = 8'd0;
               slim  = 14'd0;
               p_scl = 30;
            end
            default: begin
               half  = HALF_W'($urandom_range(1, 4));
               slim  = STRETCH_W'($urandom_range(1, 8));
               p_scl = int'($urandom_range(10, 90));
            end
         endcase
         junk = 6'($urandom_range(0, 63));
         program_reg(CSR_HALF_PHASE, {junk, half});
         program_reg(CSR_STRETCH, slim);
         if ($urandom_range(0, 3) == 0)
            program_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                        CSR_DAT_W'($urandom_range(0, 16383)));

         for (int n = 0; n < PHASE_WORDS; n++) begin
            pause_sender();
            // mostly start a byte when idle; rare stray sends while busy
            if (seq_phase == PH_IDLE)
               w.cmd = ($urandom_range(0, 99) < 80) ? CMD_SEND : CMD_TICK;
            else
               w.cmd = ($urandom_range(0, 99) < 10) ? CMD_SEND : CMD_TICK;
            case ($urandom_range(0, 9))
               0:       w.byte_in = 8'h00;
               1:       w.byte_in = 8'hFF;
               default: w.byte_in = BYTE_W'($urandom_range(0, 255));
            endcase
            if (seq_phase == PH_STRETCH)
               w.scl_level = ($urandom_range(0, 99) < p_scl);
            else
               w.scl_level = 1'($urandom_range(0, 1));
            w.sda_level = 1'($urandom_range(0, 1));
            typed_on = 1'b0;
            offer_word(w);
            rand_items++;
         end
      end

      // Drain and let the output register settle
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (bus_result_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Covered %0d words in and %0d results out over %0d register writes;",
               words_in, words_out, reg_writes);
      $display("%0d bytes completed, %0d acknowledged, %0d with a stretch timeout.",
               bytes_done, bytes_acked, bytes_expired);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/i2cbw_pkg.sv
hdl/i2cbw_if.sv
hdl/i2cbw_seq.sv
hdl/i2c_master_byte_writer.sv
hdl/i2cbw_check.sv
verif/i2c_master_byte_writer_tb.sv
